FILE: rtl/ctds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the character translate / delete / squeeze filter.
package ctds_pkg;

    localparam int CP_W      = 21;
    localparam int LEN_W     = 10;
    localparam int SLOT_W    = 9;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PROCESS      = 2'd0,
        CMD_LOAD_FIRST   = 2'd1,
        CMD_LOAD_SECOND  = 2'd2,
        CMD_LOAD_SQUEEZE = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMPLEMENT_FIRST   = 3'd0,
        REG_DELETE_ENABLE      = 3'd1,
        REG_SQUEEZE_ENABLE     = 3'd2,
        REG_TRANSLATE_ENABLE   = 3'd3,
        REG_SQUEEZE_INVERT     = 3'd4,
        REG_FIRST_LENGTH       = 3'd5,
        REG_SECOND_LENGTH      = 3'd6,
        REG_SQUEEZE_LENGTH     = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK_XLAT,
        ST_WALK_SQZ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             complement_first;
        logic             delete_enable;
        logic             squeeze_enable;
        logic             translate_enable;
        logic             squeeze_invert;
        logic [LEN_W-1:0] first_length;
        logic [LEN_W-1:0] second_length;
        logic [LEN_W-1:0] squeeze_length;
    } cfg_t;

    // Table write broadcast to every cell.
    typedef struct packed {
        logic              wr_first;
        logic              wr_second;
        logic              wr_squeeze;
        logic [SLOT_W-1:0] slot;
        logic [CP_W-1:0]   value;
    } load_t;

    // Search token that travels down the cell chain.
    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] key;
        logic            hit_first;
        logic            pick_valid;
        logic [CP_W-1:0] pick;
        logic [CP_W-1:0] last_second;
        logic            hit_squeeze;
    } tok_t;

endpackage

FILE: rtl/char_translate_delete_squeeze_top.sv
`timescale 1ns / 1ps
// Top level of the character translate / delete / squeeze filter.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   item     | item_valid / item_stall  | command, slot, code_point
//   result   | result_valid / result_stall | out_code_point
//   cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// A load command leaves the block idle. A character walks the chain of SET_DEPTH cells,
// one cell per cycle, and a second walk checks the squeeze set when the translated
// character repeats the last result; a dropped character gives no result.
// A stalled result holds the block in ST_EMIT until the output register is free.
// Reset clears the control state and the configuration; table entries stay undefined.
// A finished result waits in the output register while the next item is taken.
module char_translate_delete_squeeze_top #(
    parameter int SET_DEPTH = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [ctds_pkg::CMD_W-1:0]         command,
    input  logic [ctds_pkg::SLOT_W-1:0]        slot,
    input  logic [ctds_pkg::CP_W-1:0]          code_point,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [ctds_pkg::CP_W-1:0]          out_code_point,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ctds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctds_pkg::LEN_W-1:0]         cfg_data
);
    import ctds_pkg::*;

    localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

    cfg_t             cfg_reg;
    state_t           state_reg;
    state_t           state_next;
    tok_t             head_reg;
    tok_t             head_next;
    tok_t             chain [0:SET_DEPTH];
    tok_t             tail;
    load_t            load;
    logic [CP_W-1:0]  orig_reg;
    logic [CP_W-1:0]  cur_reg;
    logic [CP_W-1:0]  cur_next;
    logic             have_last_reg;
    logic [CP_W-1:0]  last_emitted_reg;
    logic             out_valid_reg;
    logic [CP_W-1:0]  out_cp_reg;
    logic             accept;
    logic             emit;
    logic             out_free;
    logic [IDX_W-1:0] last_second_idx;
    logic [CP_W-1:0]  xlat;
    logic [CP_W-1:0]  current;
    logic             deleted;
    logic             squeeze_check;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COMPLEMENT_FIRST:   cfg_reg.complement_first   <= cfg_data[0];
                REG_DELETE_ENABLE:      cfg_reg.delete_enable      <= cfg_data[0];
                REG_SQUEEZE_ENABLE:     cfg_reg.squeeze_enable     <= cfg_data[0];
                REG_TRANSLATE_ENABLE:   cfg_reg.translate_enable   <= cfg_data[0];
                REG_SQUEEZE_INVERT:     cfg_reg.squeeze_invert     <= cfg_data[0];
                REG_FIRST_LENGTH:       cfg_reg.first_length       <= cfg_data;
                REG_SECOND_LENGTH:      cfg_reg.second_length      <= cfg_data;
                REG_SQUEEZE_LENGTH:     cfg_reg.squeeze_length     <= cfg_data;
            endcase
        end
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        load            = '0;
        load.slot       = slot;
        load.value      = code_point;
        load.wr_first   = accept && (cmd_t'(command) == CMD_LOAD_FIRST);
        load.wr_second  = accept && (cmd_t'(command) == CMD_LOAD_SECOND);
        load.wr_squeeze = accept && (cmd_t'(command) == CMD_LOAD_SQUEEZE);
    end

    // Last second-set entry in use; a length beyond the table means the final cell.
    always_comb
    begin
        if (CMP_W'(cfg_reg.second_length) >= CMP_W'(SET_DEPTH))
        begin
            last_second_idx = IDX_W'(SET_DEPTH - 1);
        end
        else
        begin
            last_second_idx = IDX_W'(CMP_W'(cfg_reg.second_length) - CMP_W'(1));
        end
    end

    assign chain[0] = head_reg;

    genvar gi;
    generate
        for (gi = 0; gi < SET_DEPTH; gi++)
        begin : g_cell
            ctds_cell #(
                .INDEX (gi),
                .IDX_W (IDX_W),
                .CMP_W (CMP_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cfg      (cfg_reg),
                .load     (load),
                .last_idx (last_second_idx),
                .tok_in   (chain[gi]),
                .tok_out  (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[SET_DEPTH];

    always_comb
    begin
        if (cfg_reg.second_length == '0)
        begin
            xlat = orig_reg;
        end
        else if (cfg_reg.complement_first)
        begin
            xlat = tail.hit_first ? orig_reg : tail.last_second;
        end
        else if (tail.hit_first)
        begin
            xlat = tail.pick_valid ? tail.pick : tail.last_second;
        end
        else
        begin
            xlat = orig_reg;
        end
    end

    assign current       = cfg_reg.translate_enable ? xlat : orig_reg;
    assign deleted       = cfg_reg.delete_enable &&
                           (tail.hit_first != cfg_reg.complement_first);
    assign squeeze_check = cfg_reg.squeeze_enable && have_last_reg &&
                           (current == last_emitted_reg);
    assign out_free      = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        head_next  = '0;
        cur_next   = cur_reg;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd_t'(command) == CMD_PROCESS))
                begin
                    head_next.valid = 1'b1;
                    head_next.key   = code_point;
                    state_next      = ST_WALK_XLAT;
                end
            end
            ST_WALK_XLAT:
            begin
                if (tail.valid)
                begin
                    cur_next = current;
                    if (deleted)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (squeeze_check)
                    begin
                        // The translated character needs its own walk for squeeze membership.
                        head_next.valid = 1'b1;
                        head_next.key   = current;
                        state_next      = ST_WALK_SQZ;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_WALK_SQZ:
            begin
                if (tail.valid)
                begin
                    if (tail.hit_squeeze != cfg_reg.squeeze_invert)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            have_last_reg    <= 1'b0;
            last_emitted_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            if (emit)
            begin
                out_valid_reg    <= 1'b1;
                have_last_reg    <= 1'b1;
                last_emitted_reg <= cur_reg;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (accept)
        begin
            orig_reg <= code_point;
        end
        if (emit)
        begin
            out_cp_reg <= cur_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign out_code_point = out_cp_reg;

endmodule

FILE: rtl/ctds_cell.sv
`timescale 1ns / 1ps
// One chain cell: holds one entry of each set table and updates the passing token.
module ctds_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 9,
    parameter int CMP_W = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctds_pkg::cfg_t       cfg,
    input  ctds_pkg::load_t      load,
    input  logic [IDX_W-1:0]     last_idx,
    input  ctds_pkg::tok_t       tok_in,
    output ctds_pkg::tok_t       tok_out
);
    import ctds_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [CP_W-1:0] first_reg;
    logic [CP_W-1:0] second_reg;
    logic [CP_W-1:0] squeeze_reg;
    logic            mine;
    logic            use_first;
    logic            use_second;
    logic            use_squeeze;
    logic            is_last;
    logic            first_eq;
    tok_t            tok_next;
    tok_t            tok_reg;

    assign mine        = (CMP_W'(load.slot) == MY_IDX);
    assign use_first   = (MY_IDX < CMP_W'(cfg.first_length));
    assign use_second  = (MY_IDX < CMP_W'(cfg.second_length));
    assign use_squeeze = (MY_IDX < CMP_W'(cfg.squeeze_length));
    assign is_last     = (last_idx == IDX_W'(INDEX));

    always_ff @(posedge clk)
    begin
        if (load.wr_first && mine)
        begin
            first_reg <= load.value;
        end
        if (load.wr_second && mine)
        begin
            second_reg <= load.value;
        end
        if (load.wr_squeeze && mine)
        begin
            squeeze_reg <= load.value;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        first_eq = use_first && (first_reg == tok_in.key);
        // Only the earliest match in the first set selects a second-set entry.
        if (first_eq && !tok_in.hit_first && use_second)
        begin
            tok_next.pick_valid = 1'b1;
            tok_next.pick       = second_reg;
        end
        if (first_eq)
        begin
            tok_next.hit_first = 1'b1;
        end
        if (is_last)
        begin
            tok_next.last_second = second_reg;
        end
        if (use_squeeze && (squeeze_reg == tok_in.key))
        begin
            tok_next.hit_squeeze = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/ctds_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the filter top level, with its bind statement.
module ctds_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_stall,
    input logic [ctds_pkg::CMD_W-1:0]         command,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic [ctds_pkg::CP_W-1:0]          out_code_point
);
    import ctds_pkg::*;

    // A result that is held back keeps its value until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_code_point))
        else $error("result changed while stalled");

    // A character transfer occupies the block for the following cycle.
    a_process_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (command == CMD_PROCESS) |=> item_stall)
        else $error("block ready right after a character transfer");

    // A table load completes in its own cycle.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (command != CMD_PROCESS) |=> !item_stall)
        else $error("block busy after a table load");

    // A new result only appears at the end of a character's work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared while the block was idle");

endmodule

bind char_translate_delete_squeeze_top ctds_checker u_ctds_checker (.*);

FILE: bench/char_translate_delete_squeeze_top_tb.sv
`timescale 1ns / 1ps
// Testbench of the character translate / delete / squeeze filter with a self-checking scoreboard.
module char_translate_delete_squeeze_top_tb;
    import ctds_pkg::*;

    localparam int SET_DEPTH       = 512;
    localparam int TOTAL_ITEMS     = 1800;
    localparam int MIN_PHASES      = 8;
    localparam int SETTLE_CYCLES   = 2 * SET_DEPTH + 16;
    localparam int HOLD_OFF_CYCLES = 5000;
    localparam int MAX_REPORTS     = 10;

    // Scoreboard: mirrors the tables and the filter state and predicts each output character.
    class filter_scoreboard;
        logic [CP_W-1:0]  sets [1:3][SET_DEPTH];
        logic [LEN_W-1:0] len [1:3];
        bit               comp_first;
        bit               del_en;
        bit               sqz_en;
        bit               xlat_en;
        bit               sqz_comp;
        bit               have_last;
        logic [CP_W-1:0]  last_out;
        logic [CP_W-1:0]  expected_chars [$];
        int               errors;

        function new();
            for (int t = 1; t <= 3; t++)
            begin
                len[t] = '0;
            end
            comp_first = 1'b0;
            del_en     = 1'b0;
            sqz_en     = 1'b0;
            xlat_en    = 1'b0;
            sqz_comp   = 1'b0;
            have_last  = 1'b0;
            last_out   = '0;
            errors     = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [LEN_W-1:0] data);
            case (idx)
                REG_COMPLEMENT_FIRST:   comp_first = data[0];
                REG_DELETE_ENABLE:      del_en = data[0];
                REG_SQUEEZE_ENABLE:     sqz_en = data[0];
                REG_TRANSLATE_ENABLE:   xlat_en = data[0];
                REG_SQUEEZE_INVERT:     sqz_comp = data[0];
                REG_FIRST_LENGTH:       len[CMD_LOAD_FIRST] = data;
                REG_SECOND_LENGTH:      len[CMD_LOAD_SECOND] = data;
                REG_SQUEEZE_LENGTH:     len[CMD_LOAD_SQUEEZE] = data;
                default: ;
            endcase
        endfunction

        function int used_len(cmd_t which);
            return (len[which] > SET_DEPTH) ? SET_DEPTH : int'(len[which]);
        endfunction

        function bit in_set(cmd_t which, logic [CP_W-1:0] ch);
            int n;
            n = used_len(which);
            for (int i = 0; i < n; i++)
            begin
                if (sets[which][i] == ch)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [CP_W-1:0] translated(logic [CP_W-1:0] ch);
            int n1;
            int n2;
            n1 = used_len(CMD_LOAD_FIRST);
            n2 = used_len(CMD_LOAD_SECOND);
            if (n2 == 0)
                return ch;
            if (comp_first)
                return in_set(CMD_LOAD_FIRST, ch) ? ch : sets[CMD_LOAD_SECOND][n2-1];
            for (int i = 0; i < n1; i++)
            begin
                if (sets[CMD_LOAD_FIRST][i] == ch)
                    return (i < n2) ? sets[CMD_LOAD_SECOND][i] : sets[CMD_LOAD_SECOND][n2-1];
            end
            return ch;
        endfunction

        function void note_item(cmd_t cmd, logic [SLOT_W-1:0] slot, logic [CP_W-1:0] cp);
            logic [CP_W-1:0] cur;
            if (cmd != CMD_PROCESS)
            begin
                if (slot < SET_DEPTH)
                    sets[cmd][slot] = cp;
                return;
            end
            cur = xlat_en ? translated(cp) : cp;
            // Delete looks at the original character, not the translated one.
            if (del_en && (in_set(CMD_LOAD_FIRST, cp) != comp_first))
                return;
            if (sqz_en && have_last && cur == last_out &&
                (in_set(CMD_LOAD_SQUEEZE, cur) != sqz_comp))
                return;
            have_last = 1'b1;
            last_out  = cur;
            expected_chars.push_back(cur);
        endfunction

        function void check_result(logic [CP_W-1:0] got);
            logic [CP_W-1:0] want;
            if (expected_chars.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output transfer: out_code_point %h", got);
                return;
            end
            want = expected_chars.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("out_code_point mismatch: expected %h, actual %h", want, got);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic [CMD_W-1:0]     command;
    logic [SLOT_W-1:0]    slot;
    logic [CP_W-1:0]      code_point;
    logic                 result_valid;
    logic                 result_stall;
    logic [CP_W-1:0]      out_code_point;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    filter_scoreboard     sb;
    bit                   steady;
    bit                   hold_off_req;
    bit                   loaded [1:3][SET_DEPTH];
    logic [CP_W-1:0]      char_pool [10];
    int                   sent_items = 0;

    char_translate_delete_squeeze_top #(
        .SET_DEPTH(SET_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .slot          (slot),
        .code_point    (code_point),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_code_point(out_code_point),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transfers are observed at the rising edge, before the block updates its outputs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
            if (item_valid && !item_stall)
                sb.note_item(cmd_t'(command), slot, code_point);
            if (result_valid && !result_stall)
                sb.check_result(out_code_point);
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            result_stall <= !steady && ($urandom_range(99) < 23);
        end
    end

    initial
    begin
        #200_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [CP_W-1:0] random_char();
        logic [CP_W-1:0] ch;
        if ($urandom_range(99) < 75)
            ch = char_pool[$urandom_range(9)];
        else
            ch = CP_W'($urandom);
        return ch;
    endfunction

    // Number of leading table entries that have been written.
    function automatic int loaded_prefix(cmd_t which);
        int n;
        n = 0;
        while (n < SET_DEPTH && loaded[which][n])
            n++;
        return n;
    endfunction

    // Lengths never reach past the written prefix, so no unwritten entry is ever read.
    function automatic logic [LEN_W-1:0] pick_length(cmd_t which);
        int pre;
        int r;
        pre = loaded_prefix(which);
        r   = $urandom_range(9);
        if (r < 2)
            return '0;
        if (r < 5)
            return LEN_W'(pre);
        if (r == 5 && pre == SET_DEPTH)
            return LEN_W'($urandom_range(1023, SET_DEPTH + 1));
        return LEN_W'($urandom_range(pre, 0));
    endfunction

    task automatic send_item(cmd_t cmd, logic [SLOT_W-1:0] s, logic [CP_W-1:0] cp);
        while (!steady && $urandom_range(99) < 23)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        slot       <= s;
        code_point <= cp;
        if (cmd != CMD_PROCESS)
            loaded[cmd][s] = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        sent_items++;
        @(negedge clk);
    endtask

    // A dropped character gives no output, so a full walk of slack follows the last one.
    task automatic wait_for_drain();
        item_valid <= 1'b0;
        while (sb.expected_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [LEN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Flag registers only use bit 0; the upper bits carry random junk.
    task automatic apply_config(bit cf, bit de, bit se, bit te, bit sc,
                                logic [LEN_W-1:0] l1, logic [LEN_W-1:0] l2,
                                logic [LEN_W-1:0] l3);
        write_reg(REG_COMPLEMENT_FIRST, {(LEN_W-1)'($urandom), cf});
        write_reg(REG_DELETE_ENABLE, {(LEN_W-1)'($urandom), de});
        write_reg(REG_SQUEEZE_ENABLE, {(LEN_W-1)'($urandom), se});
        write_reg(REG_TRANSLATE_ENABLE, {(LEN_W-1)'($urandom), te});
        write_reg(REG_SQUEEZE_INVERT, {(LEN_W-1)'($urandom), sc});
        write_reg(REG_FIRST_LENGTH, l1);
        write_reg(REG_SECOND_LENGTH, l2);
        write_reg(REG_SQUEEZE_LENGTH, l3);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int   p;
        int   n;
        int   roll;
        int   pre;
        cmd_t which;
        logic [SLOT_W-1:0] s;

        sb           = new();
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        command      = CMD_PROCESS;
        slot         = '0;
        code_point   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_COMPLEMENT_FIRST;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_off_req = 1'b0;

        char_pool[0] = 21'h000000;
        char_pool[1] = 21'h1FFFFF;
        char_pool[2] = 21'h10FFFF;
        for (int i = 3; i < 10; i++)
        begin
            char_pool[i] = CP_W'($urandom);
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: loads of every table at both slot extremes, pass-through with everything off.
        send_item(CMD_LOAD_FIRST, 9'd0, 21'h000061);
        send_item(CMD_LOAD_FIRST, 9'd1, 21'h000062);
        send_item(CMD_LOAD_SECOND, 9'd0, 21'h000078);
        send_item(CMD_LOAD_SQUEEZE, 9'd0, 21'h000078);
        send_item(CMD_LOAD_FIRST, 9'd511, 21'h1FFFFF);
        send_item(CMD_LOAD_SECOND, 9'd511, 21'h000000);
        send_item(CMD_LOAD_SQUEEZE, 9'd511, 21'h1FFFFF);
        send_item(CMD_PROCESS, 9'd0, 21'h000000);
        send_item(CMD_PROCESS, 9'd511, 21'h1FFFFF);
        send_item(CMD_PROCESS, 9'd0, 21'h10FFFF);
        send_item(CMD_PROCESS, 9'd0, 21'h110000);
        send_item(CMD_PROCESS, 9'd0, 21'h000061);

        // Short second set maps the second match to its last entry; repeats get squeezed.
        wait_for_drain();
        apply_config(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 10'd2, 10'd1, 10'd1);
        send_item(CMD_PROCESS, 9'd0, 21'h000061);
        send_item(CMD_PROCESS, 9'd0, 21'h000062);
        send_item(CMD_PROCESS, 9'd0, 21'h000062);
        send_item(CMD_PROCESS, 9'd0, 21'h000063);
        send_item(CMD_PROCESS, 9'd0, 21'h000061);

        // Complemented delete with an empty second set, then a complemented squeeze set.
        wait_for_drain();
        apply_config(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 10'd2, 10'd0, 10'd1);
        send_item(CMD_PROCESS, 9'd0, 21'h000061);
        send_item(CMD_PROCESS, 9'd0, 21'h000063);
        wait_for_drain();
        apply_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 10'd2, 10'd0, 10'd1);
        send_item(CMD_PROCESS, 9'd0, 21'h000061);

        p = 0;
        while (sent_items < TOTAL_ITEMS || p < MIN_PHASES)
        begin
            wait_for_drain();
            steady = (p == 3);
            if (p == 5)
                hold_off_req = 1'b1;
            if (p == 6)
                apply_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)),
                             10'h3FF, 10'h3FF, 10'h3FF);
            else if (p == 7)
                apply_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                             LEN_W'(SET_DEPTH), LEN_W'(SET_DEPTH), LEN_W'(SET_DEPTH));
            else
                apply_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)),
                             pick_length(CMD_LOAD_FIRST), pick_length(CMD_LOAD_SECOND),
                             pick_length(CMD_LOAD_SQUEEZE));

            // Three early phases fill one whole table each, so that full lengths can follow.
            if (p >= 2 && p <= 4)
            begin
                which = cmd_t'(p - 1);
                for (int i = 0; i < SET_DEPTH; i++)
                begin
                    if (!loaded[which][i])
                        send_item(which, SLOT_W'(i), random_char());
                end
            end

            n = $urandom_range(60, 20);
            repeat (n)
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                begin
                    send_item(cmd_t'($urandom_range(3, 1)), SLOT_W'($urandom), CP_W'($urandom));
                end
                else if (roll < 30)
                begin
                    which = cmd_t'($urandom_range(3, 1));
                    pre   = loaded_prefix(which);
                    if (pre < SET_DEPTH && $urandom_range(1))
                        s = SLOT_W'(pre);
                    else
                        s = SLOT_W'($urandom_range(SET_DEPTH - 1));
                    send_item(which, s, random_char());
                end
                else
                begin
                    send_item(CMD_PROCESS, SLOT_W'($urandom), random_char());
                end
            end
            p++;
        end

        steady = 1'b0;
        wait_for_drain();
        if (sb.errors == 0 && sb.expected_chars.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ctds_pkg.sv
rtl/ctds_cell.sv
rtl/char_translate_delete_squeeze_top.sv
rtl/ctds_checker.sv
bench/char_translate_delete_squeeze_top_tb.sv
